// ----- rtl/core/frame_statistics_monitor_defines.svh -----
// assertion macros shared by the frame statistics monitor rtl
// no dependencies; included by files that carry assertions
`ifndef FRAME_STATISTICS_MONITOR_DEFINES_SVH
`define FRAME_STATISTICS_MONITOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FSTAT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fstat assertion failed");
`define FSTAT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("fstat forbidden condition");
`else
`define FSTAT_ASSERT(lbl, clk, rstn, prop)
`define FSTAT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- rtl/core/fstat_pkg.sv -----
// constants and types for the frame statistics monitor
// no dependencies
package fstat_pkg;
    localparam int DIV_NW   = 34;
    localparam int DIV_DW   = 32;
    localparam int RATE_W   = 24;
    localparam int RATE_SCALE = 256000;
    localparam logic [15:0] MIN_TIME_RST = 16'd999;
    localparam logic [15:0] INTERVAL_RST = 16'd1000;
    // reciprocal of ten, exact floor for numerators below 2^30
    localparam logic [27:0] DIV10_MUL   = 28'd214748365;
    localparam int          DIV10_SHIFT = 31;

    typedef enum logic [1:0] {
        OP_FT,
        OP_DC,
        OP_RATE,
        OP_EMA
    } t_div_op;
endpackage

// ----- rtl/core/fstat_if.sv -----
// channel interfaces: frame report in, statistics out, interval config
// no dependencies
interface fstat_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_time_ms;
    logic [15:0] draw_calls;
    logic [31:0] now_ms;
    modport source (output valid, frame_time_ms, draw_calls, now_ms, input ready);
    modport sink   (input valid, frame_time_ms, draw_calls, now_ms, output ready);
endinterface

interface fstat_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] avg_frame_time;
    logic [15:0] min_frame_time;
    logic [15:0] max_frame_time;
    logic [23:0] current_rate;
    logic [23:0] average_rate;
    logic [23:0] avg_draw_calls;
    logic [15:0] min_draw_calls;
    logic [15:0] max_draw_calls;
    logic [31:0] total_draw_calls;
    logic        rate_updated;
    modport source (output valid, avg_frame_time, min_frame_time, max_frame_time,
                    current_rate, average_rate, avg_draw_calls, min_draw_calls,
                    max_draw_calls, total_draw_calls, rate_updated, input ready);
    modport sink   (input valid, avg_frame_time, min_frame_time, max_frame_time,
                    current_rate, average_rate, avg_draw_calls, min_draw_calls,
                    max_draw_calls, total_draw_calls, rate_updated, output ready);
endinterface

interface fstat_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/fstat_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
module fstat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/fstat_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
// depends on fstat_pkg
`include "frame_statistics_monitor_defines.svh"
module fstat_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fstat_pkg::DIV_NW-1:0] i_dividend,
    input  logic [fstat_pkg::DIV_DW-1:0] i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [fstat_pkg::DIV_NW-1:0] o_quotient
);
    import fstat_pkg::*;
    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] r_quot;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   trial;
    logic              ge;
    logic [DIV_DW:0]   diff;

    assign trial = {r_rem, r_quot[DIV_NW-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
                r_quot <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
                r_quot <= {r_quot[DIV_NW-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quot;

    `FSTAT_NEVER(a_no_restart, i_clk, i_rst_n, i_start && r_busy)
    `FSTAT_ASSERT(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))
    `FSTAT_NEVER(a_busy_cnt, i_clk, i_rst_n, r_busy && r_cnt == '0)
endmodule

// ----- rtl/core/frame_statistics_monitor.sv -----
// frame statistics monitor top level: min/max, window averages, frame rate
// depends on fstat_pkg, fstat_if, fstat_ram, fstat_div
//
// channel  dir  port   word
// report   in   i_in   frame_time_ms, draw_calls, now_ms
// stats    out  o_res  averages, extremes, rates, total, rate_updated
// config   in   i_cfg  update_interval_ms
//
// the path from accept to stats word: history write, two divides of 34 quotient bits
// (one quotient bit per cycle) and the output state
// a rate update adds a third divide and, with a nonzero average, the /10 step;
// the next report is taken in the cycle after the output state
// synchronous active-low reset; history ram needs no clearing pass
// a new report is taken while the previous word waits on o_res, and stalls in
// its output state until that word is taken
`include "frame_statistics_monitor_defines.svh"
module frame_statistics_monitor #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fstat_in_if.sink   i_in,
    fstat_out_if.source o_res,
    fstat_cfg_if.sink  i_cfg
);
    import fstat_pkg::*;
    localparam int IW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUMW = 16 + IW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMA,
        S_OUT
    } t_state;

    t_state  r_state;
    t_div_op r_op;

    logic [15:0]     r_interval;
    logic [15:0]     r_ft;
    logic [15:0]     r_dc;
    logic [IW-1:0]   r_widx;
    logic [CW-1:0]   r_fill;
    logic            r_full;
    logic [SUMW-1:0] r_ft_sum;
    logic [SUMW-1:0] r_dc_sum;
    logic [15:0]     r_min_t, r_max_t, r_min_d, r_max_d;
    logic [15:0]     r_frames;
    logic [15:0]     r_fcnt;
    logic [31:0]     r_last;
    logic [31:0]     r_elapsed;
    logic            r_upd;
    logic [33:0]     r_num;
    logic [23:0]     r_rate_now, r_rate_avg;
    logic [23:0]     r_avg_ft, r_avg_dc;
    logic [31:0]     r_total;
    logic            r_ovalid;

    logic [31:0]       rd_data;
    logic              div_start, div_busy, div_done;
    logic [DIV_NW-1:0] div_num, div_q;
    logic [DIV_DW-1:0] div_den;
    logic [15:0]       n_frames;
    logic [31:0]       n_elapsed;
    logic [15:0]       eff_interval;
    logic [32:0]       n_total;
    logic [27:0]       ema_num;
    logic [55:0]       ema_prod;
    logic [23:0]       ema_q;
    logic [23:0]       rate_sat;
    logic              in_acc;
    logic [SUMW-1:0]   old_ft, old_dc;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign n_frames     = (r_frames == 16'hFFFF) ? r_frames : r_frames + 16'd1;
    assign n_elapsed    = i_in.now_ms - r_last;
    assign eff_interval = (r_interval == 16'd0) ? 16'd1 : r_interval;
    assign n_total      = {1'b0, r_total} + {17'd0, i_in.draw_calls};
    assign ema_num      = {1'b0, r_rate_avg, 3'd0} + {4'd0, r_rate_avg} + {4'd0, r_rate_now};
    assign ema_prod     = {28'd0, ema_num} * {28'd0, DIV10_MUL};
    assign ema_q        = ema_prod[DIV10_SHIFT+23:DIV10_SHIFT];
    assign rate_sat     = (div_q > DIV_NW'(24'hFFFFFF)) ? 24'hFFFFFF : div_q[23:0];
    assign old_ft       = r_full ? SUMW'(rd_data[31:16]) : '0;
    assign old_dc       = r_full ? SUMW'(rd_data[15:0]) : '0;

    always_comb begin
        case (r_op)
            OP_FT: begin
                div_num = DIV_NW'({r_ft_sum, 8'd0});
                div_den = DIV_DW'(r_fill);
            end
            OP_DC: begin
                div_num = DIV_NW'({r_dc_sum, 8'd0});
                div_den = DIV_DW'(r_fill);
            end
            OP_RATE: begin
                div_num = r_num;
                div_den = r_elapsed;
            end
            default: begin
                div_num = '0;
                div_den = DIV_DW'(1);
            end
        endcase
    end

    assign div_start = (r_state == S_DIV_GO);

    fstat_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (r_state == S_READ),
        .i_waddr (r_widx),
        .i_wdata ({r_ft, r_dc}),
        .i_raddr (r_widx),
        .o_rdata (rd_data)
    );

    fstat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_op       <= OP_FT;
            r_interval <= INTERVAL_RST;
            r_widx     <= '0;
            r_fill     <= '0;
            r_full     <= 1'b0;
            r_ft_sum   <= '0;
            r_dc_sum   <= '0;
            r_min_t    <= MIN_TIME_RST;
            r_max_t    <= '0;
            r_min_d    <= 16'hFFFF;
            r_max_d    <= '0;
            r_frames   <= '0;
            r_last     <= '0;
            r_rate_now <= '0;
            r_rate_avg <= '0;
            r_total    <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_interval <= i_cfg.data;
            end
            if (r_ovalid && o_res.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ft <= i_in.frame_time_ms;
                        r_dc <= i_in.draw_calls;
                        if (i_in.frame_time_ms < r_min_t) r_min_t <= i_in.frame_time_ms;
                        if (i_in.frame_time_ms > r_max_t) r_max_t <= i_in.frame_time_ms;
                        if (i_in.draw_calls < r_min_d) r_min_d <= i_in.draw_calls;
                        if (i_in.draw_calls > r_max_d) r_max_d <= i_in.draw_calls;
                        r_total   <= n_total[32] ? 32'hFFFF_FFFF : n_total[31:0];
                        r_fcnt    <= n_frames;
                        r_elapsed <= n_elapsed;
                        r_full    <= (r_fill == CW'(HISTORY_DEPTH));
                        if (n_elapsed >= {16'd0, eff_interval}) begin
                            r_upd    <= 1'b1;
                            r_frames <= '0;
                            r_last   <= i_in.now_ms;
                        end else begin
                            r_upd    <= 1'b0;
                            r_frames <= n_frames;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_ft_sum <= r_ft_sum - old_ft + SUMW'(r_ft);
                    r_dc_sum <= r_dc_sum - old_dc + SUMW'(r_dc);
                    if (!r_full) r_fill <= r_fill + 1'b1;
                    r_widx <= (r_widx == IW'(HISTORY_DEPTH - 1)) ? '0 : r_widx + 1'b1;
                    r_num  <= {18'd0, r_fcnt} * 34'(RATE_SCALE);
                    r_op   <= OP_FT;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        case (r_op)
                            OP_FT: begin
                                r_avg_ft <= div_q[23:0];
                                r_op     <= OP_DC;
                                r_state  <= S_DIV_GO;
                            end
                            OP_DC: begin
                                r_avg_dc <= div_q[23:0];
                                r_op     <= OP_RATE;
                                r_state  <= r_upd ? S_DIV_GO : S_OUT;
                            end
                            OP_RATE: begin
                                r_rate_now <= rate_sat;
                                if (r_rate_avg == '0) begin
                                    r_rate_avg <= rate_sat;
                                    r_state    <= S_OUT;
                                end else begin
                                    r_op    <= OP_EMA;
                                    r_state <= S_EMA;
                                end
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_EMA: begin
                    r_rate_avg <= ema_q;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_res.ready) begin
                        o_res.avg_frame_time   <= r_avg_ft;
                        o_res.min_frame_time   <= r_min_t;
                        o_res.max_frame_time   <= r_max_t;
                        o_res.current_rate     <= r_rate_now;
                        o_res.average_rate     <= r_rate_avg;
                        o_res.avg_draw_calls   <= r_avg_dc;
                        o_res.min_draw_calls   <= r_min_d;
                        o_res.max_draw_calls   <= r_max_d;
                        o_res.total_draw_calls <= r_total;
                        o_res.rate_updated     <= r_upd;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid = r_ovalid;

    `FSTAT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> r_state == S_READ)
    `FSTAT_NEVER(a_fill_bound, i_clk, i_rst_n, r_fill > CW'(HISTORY_DEPTH))
    `FSTAT_NEVER(a_start_while_busy, i_clk, i_rst_n, div_start && div_busy)
    `FSTAT_ASSERT(a_rate_div_only_on_update, i_clk, i_rst_n,
        (div_start && r_op == OP_RATE) |-> r_upd)
endmodule

// ----- dv/fstat_checker.sv -----
// checker for the frame statistics monitor: watches report, stats and config channels
// depends on fstat_if; predicts each stats word, compares it whole and prints the fields on a mismatch
`timescale 1ns / 100ps
module fstat_checker #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fstat_in_if.sink    i_in_mon,
    fstat_out_if.sink   i_res_mon,
    fstat_cfg_if.sink   i_cfg_mon,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [23:0] avg_ft;
        logic [15:0] min_ft;
        logic [15:0] max_ft;
        logic [23:0] cur_rate;
        logic [23:0] avg_rate;
        logic [23:0] avg_dc;
        logic [15:0] min_dc;
        logic [15:0] max_dc;
        logic [31:0] total_dc;
        logic        updated;
    } t_stats;

    t_stats      stats_q[$];
    logic [15:0] ft_hist[HISTORY_DEPTH];
    logic [15:0] dc_hist[HISTORY_DEPTH];
    int unsigned wr_idx, fill;
    logic [31:0] ft_sum, dc_sum;
    logic [15:0] min_ft, max_ft, min_dc, max_dc, interval, frames_cnt;
    logic [31:0] last_ms, total_dc;
    logic [23:0] rate_cur, rate_ema;

    assign o_pending = stats_q.size();

    function automatic logic [23:0] q8_avg(logic [31:0] sum, int unsigned cnt);
        logic [63:0] q;
        if (cnt == 0) return 24'd0;
        q = {24'd0, sum, 8'd0} / cnt;
        return q[23:0];
    endfunction

    task automatic predict_stats(logic [15:0] ft, logic [15:0] dc, logic [31:0] now);
        t_stats s;
        logic [31:0] elapsed, intv, fr;
        logic [63:0] r;
        if (ft < min_ft) min_ft = ft;
        if (ft > max_ft) max_ft = ft;
        if (dc < min_dc) min_dc = dc;
        if (dc > max_dc) max_dc = dc;
        if (fill >= HISTORY_DEPTH) begin
            ft_sum -= ft_hist[wr_idx];
            dc_sum -= dc_hist[wr_idx];
        end else begin
            fill++;
        end
        ft_hist[wr_idx] = ft;
        dc_hist[wr_idx] = dc;
        ft_sum += ft;
        dc_sum += dc;
        wr_idx = (wr_idx + 1 >= HISTORY_DEPTH) ? 0 : wr_idx + 1;
        fr = (frames_cnt == 16'hffff) ? 32'hffff : frames_cnt + 1;
        intv = (interval == 0) ? 1 : interval;
        elapsed = now - last_ms;
        s.updated = 1'b0;
        if (elapsed >= intv) begin
            r = (64'(fr) * 64'd256000) / elapsed;
            rate_cur = (r > 64'hffffff) ? 24'hffffff : r[23:0];
            if (rate_ema == 0) rate_ema = rate_cur;
            else rate_ema = 24'((64'(rate_ema) * 9 + rate_cur) / 10);
            frames_cnt = 0;
            last_ms = now;
            s.updated = 1'b1;
        end else begin
            frames_cnt = fr[15:0];
        end
        total_dc = (total_dc > 32'hffffffff - dc) ? 32'hffffffff : total_dc + dc;
        s.avg_ft = q8_avg(ft_sum, fill);
        s.min_ft = min_ft;
        s.max_ft = max_ft;
        s.cur_rate = rate_cur;
        s.avg_rate = rate_ema;
        s.avg_dc = q8_avg(dc_sum, fill);
        s.min_dc = min_dc;
        s.max_dc = max_dc;
        s.total_dc = total_dc;
        stats_q.push_back(s);
    endtask

    always @(posedge i_clk) begin
        t_stats exp_s, got;
        if (!i_rst_n) begin
            stats_q.delete();
            wr_idx = 0; fill = 0; ft_sum = 0; dc_sum = 0;
            min_ft = 16'd999; max_ft = 0; min_dc = 16'hffff; max_dc = 0;
            interval = 16'd1000; frames_cnt = 0; last_ms = 0; total_dc = 0;
            rate_cur = 0; rate_ema = 0;
            o_fail_count = 0;
        end else begin
            if (i_res_mon.valid && i_res_mon.ready) begin
                got = {i_res_mon.avg_frame_time, i_res_mon.min_frame_time,
                       i_res_mon.max_frame_time, i_res_mon.current_rate,
                       i_res_mon.average_rate, i_res_mon.avg_draw_calls,
                       i_res_mon.min_draw_calls, i_res_mon.max_draw_calls,
                       i_res_mon.total_draw_calls, i_res_mon.rate_updated};
                if (stats_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected stats word %h", got);
                end else begin
                    exp_s = stats_q.pop_front();
                    if (got !== exp_s) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("stats mismatch:");
                            $display("  avg_ft %h/%h min_ft %h/%h max_ft %h/%h",
                                     exp_s.avg_ft, got.avg_ft, exp_s.min_ft, got.min_ft,
                                     exp_s.max_ft, got.max_ft);
                            $display("  rate %h/%h ema %h/%h upd %b/%b",
                                     exp_s.cur_rate, got.cur_rate, exp_s.avg_rate,
                                     got.avg_rate, exp_s.updated, got.updated);
                            $display("  avg_dc %h/%h min_dc %h/%h max_dc %h/%h tot %h/%h",
                                     exp_s.avg_dc, got.avg_dc, exp_s.min_dc, got.min_dc,
                                     exp_s.max_dc, got.max_dc, exp_s.total_dc,
                                     got.total_dc);
                        end
                    end
                end
            end
            if (i_cfg_mon.valid && i_cfg_mon.ready) interval = i_cfg_mon.data;
            if (i_in_mon.valid && i_in_mon.ready)
                predict_stats(i_in_mon.frame_time_ms, i_in_mon.draw_calls,
                              i_in_mon.now_ms);
        end
    end
endmodule

// ----- dv/testbench.sv -----
// top of the frame statistics monitor bench: clock, reset, report and config stimulus
// depends on fstat_pkg, fstat_if, fstat_checker and the rtl
`timescale 1ns / 100ps
module testbench;
    import fstat_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending;
    logic long_hold, hold_req, drain_done;
    logic [31:0] now_ts;

    fstat_in_if  in_ch();
    fstat_out_if res_ch();
    fstat_cfg_if cfg_ch();

    frame_statistics_monitor u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_res(res_ch), .i_cfg(cfg_ch)
    );

    fstat_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_mon(in_ch), .i_res_mon(res_ch),
        .i_cfg_mon(cfg_ch), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("status: fail");
        $finish;
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        res_ch.ready <= 1'b0;
        long_hold = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !long_hold) begin
                long_hold = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (2000) @(posedge i_clk);
            end
            mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
            res_ch.ready <= (mode == 1) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    task automatic send_report(logic [15:0] ft, logic [15:0] dc, logic [31:0] now);
        in_ch.valid <= 1'b1;
        in_ch.frame_time_ms <= ft;
        in_ch.draw_calls <= dc;
        in_ch.now_ms <= now;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic idle_gap(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_interval(logic [15:0] v);
        in_ch.valid <= 1'b0;
        repeat (200) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(int n, int max_step);
        int burst;
        burst = 0;
        for (int k = 0; k < n; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 60));
            end
            burst--;
            now_ts = now_ts + $urandom_range(0, max_step);
            if ($urandom_range(0, 15) == 0) now_ts = $urandom;
            send_report(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80)),
                        ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000)),
                        now_ts);
        end
    endtask

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.frame_time_ms <= '0;
        in_ch.draw_calls <= '0;
        in_ch.now_ms <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        hold_req = 1'b0;
        now_ts = 0;
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, min/max at reset values, no update then update
        send_report(16'd0, 16'd0, 32'd0);
        send_report(16'hffff, 16'hffff, 32'd999);
        send_report(16'd1000, 16'd65535, 32'd1000);
        send_report(16'd998, 16'd1, 32'd1500);
        send_report(16'd5, 16'd7, 32'd2001);
        send_report(16'd16, 16'd300, 32'hffffffff);
        send_report(16'd16, 16'd300, 32'd5);
        // repeated maximum frame time and draw call reports
        for (int k = 0; k < 12; k++) send_report(16'hffff, 16'hffff, 32'd6 + k);

        write_interval(16'd0);
        send_report(16'd1, 16'd2, 32'd6);
        send_report(16'd1, 16'd2, 32'd6);
        send_report(16'd1, 16'd2, 32'd7);
        send_report(16'd3, 16'd4, 32'd8);
        now_ts = 8;
        random_phase(300, 3);

        write_interval(16'hffff);
        hold_req = 1'b1;
        random_phase(400, 400);
        hold_req = 1'b0;

        write_interval(16'd1);
        random_phase(300, 30);

        write_interval(16'd16);
        random_phase(420, 40);

        in_ch.valid <= 1'b0;
        drain_done = 1'b0;
        fork
            begin
                repeat (2) @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
                drain_done = 1'b1;
            end
            begin
                repeat (400000) @(posedge i_clk);
            end
        join_any
        disable fork;
        repeat (300) @(posedge i_clk);
        if (!drain_done) begin
            $display("status: fail");
        end else if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
